>>> src/llgs_pkg.sv
// Package for the LLG semi-implicit spin step: payload structs, register
// indexes and the Q8.24 rounding and saturation helpers.
// No dependencies.
`default_nettype none

package llgs_pkg;

  localparam int FRAC = 24;
  localparam int QDIV = 25;  // reciprocal quotient bits (r <= 2^24)

  localparam logic [2:0] CFG_HALF_STEP  = 3'd0;
  localparam logic [2:0] CFG_DAMPING    = 3'd1;
  localparam logic [2:0] CFG_NOISE_GAIN = 3'd2;
  localparam logic [2:0] CFG_TORQUE_X   = 3'd3;
  localparam logic [2:0] CFG_TORQUE_Y   = 3'd4;
  localparam logic [2:0] CFG_TORQUE_Z   = 3'd5;

  localparam logic signed [31:0] ONE_Q   = 32'sd16777216;
  localparam logic signed [31:0] MAX_Q   = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MIN_Q   = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic signed [31:0] eval_x;
    logic signed [31:0] eval_y;
    logic signed [31:0] eval_z;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic               noise_x_sign;
    logic               noise_y_sign;
    logic               noise_z_sign;
  } in_t;

  typedef struct packed {
    logic signed [31:0] solved_x;
    logic signed [31:0] solved_y;
    logic signed [31:0] solved_z;
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic signed [31:0] mid_z;
  } out_t;

  function automatic logic signed [39:0] ext40(input logic signed [31:0] v);
    return {{8{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > ext40(MAX_Q))      r = MAX_Q;
    else if (v < ext40(MIN_Q)) r = MIN_Q;
    else                       r = v[31:0];
    return r;
  endfunction

  // 32x32 signed product, full width
  function automatic logic signed [63:0] mul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [63:0] ae;
    logic signed [63:0] be;
    ae = {{32{a[31]}}, a};
    be = {{32{b[31]}}, b};
    return ae * be;
  endfunction

  // round to nearest (ties up) at the Q8.24 point, then saturate
  function automatic logic signed [31:0] rsat(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd8388608) >>> FRAC;
    return sat32(t[39:0]);
  endfunction

  // product with +1.0 or -1.0 in Q8.24
  function automatic logic signed [31:0] sgnmul(input logic signed [31:0] v,
                                                input logic pos);
    logic signed [31:0] r;
    if (pos)             r = v;
    else if (v == MIN_Q) r = MAX_Q;
    else                 r = -v;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/llg_semi_implicit_spin_step.sv
// Top level of the LLG semi-implicit spin step: torque build, implicit solve
// through a pipelined reciprocal, and midpoint, one spin per cycle while the output is not stalled.
// Depends on llgs_pkg.
`default_nettype none

// One spin update per beat. Each input beat carries a base spin, the spin the
// torque is evaluated at, the effective field and three noise sign bits; each
// output beat carries the solved spin and the midpoint, all Q8.24 with
// saturation. The block takes one beat every cycle unless the output stalls:
// seven stages build the torque vector, the solve matrix and the row sums, a
// restoring divider with one stage per quotient bit (25 stages) forms
// 1/(1+|A|^2), and two stages apply it and form the midpoint. The whole
// pipeline holds while a finished result is stalled at the output. Registers
// are written through the cfg port and must only change while no beat is in
// flight.
module llg_semi_implicit_spin_step (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire llgs_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output llgs_pkg::out_t      out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [2:0]          cfg_index,
  input  wire  [31:0]         cfg_data
);

  localparam int NDS = llgs_pkg::QDIV;

  logic [30:0]        half_step_r;
  logic [30:0]        damping_r;
  logic [30:0]        noise_gain_r;
  logic signed [31:0] tq_r [3];

  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_step_r  <= '0;
      damping_r    <= '0;
      noise_gain_r <= '0;
      tq_r[0]      <= '0;
      tq_r[1]      <= '0;
      tq_r[2]      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        llgs_pkg::CFG_HALF_STEP:  half_step_r  <= cfg_data[30:0];
        llgs_pkg::CFG_DAMPING:    damping_r    <= cfg_data[30:0];
        llgs_pkg::CFG_NOISE_GAIN: noise_gain_r <= cfg_data[30:0];
        llgs_pkg::CFG_TORQUE_X:   tq_r[0]      <= cfg_data;
        llgs_pkg::CFG_TORQUE_Y:   tq_r[1]      <= cfg_data;
        llgs_pkg::CFG_TORQUE_Z:   tq_r[2]      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [31:0] hs_q, dm_q, ng_q;
  assign hs_q = {1'b0, half_step_r};
  assign dm_q = {1'b0, damping_r};
  assign ng_q = {1'b0, noise_gain_r};

  // ---------------- stage 1: n x H and n x C products, n x R ----------------
  logic               v1_r;
  logic signed [31:0] b1_r [3];
  logic signed [31:0] h1_r [3];
  logic [2:0]         r1_r;
  logic signed [63:0] ph1_r [3][2];
  logic signed [63:0] pc1_r [3][2];
  logic signed [31:0] xr1_r [3];

  logic signed [31:0] b_in [3], n_in [3], h_in [3];
  logic [2:0]         r_in;

  always_comb begin
    b_in[0] = in_data.base_x;  b_in[1] = in_data.base_y;  b_in[2] = in_data.base_z;
    n_in[0] = in_data.eval_x;  n_in[1] = in_data.eval_y;  n_in[2] = in_data.eval_z;
    h_in[0] = in_data.field_x; h_in[1] = in_data.field_y; h_in[2] = in_data.field_z;
    r_in    = {in_data.noise_z_sign, in_data.noise_y_sign, in_data.noise_x_sign};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b1_r[i]     <= b_in[i];
        h1_r[i]     <= h_in[i];
        ph1_r[i][0] <= llgs_pkg::mul(n_in[(i + 1) % 3], h_in[(i + 2) % 3]);
        ph1_r[i][1] <= llgs_pkg::mul(n_in[(i + 2) % 3], h_in[(i + 1) % 3]);
        pc1_r[i][0] <= llgs_pkg::mul(n_in[(i + 1) % 3], tq_r[(i + 2) % 3]);
        pc1_r[i][1] <= llgs_pkg::mul(n_in[(i + 2) % 3], tq_r[(i + 1) % 3]);
        xr1_r[i]    <= llgs_pkg::sat32(
          llgs_pkg::ext40(llgs_pkg::sgnmul(n_in[(i + 1) % 3], r_in[(i + 2) % 3])) -
          llgs_pkg::ext40(llgs_pkg::sgnmul(n_in[(i + 2) % 3], r_in[(i + 1) % 3])));
      end
      r1_r <= r_in;
    end
  end

  // ---------------- stage 2: damping products ----------------
  logic               v2_r;
  logic signed [31:0] b2_r [3];
  logic signed [31:0] h2_r [3];
  logic [2:0]         r2_r;
  logic signed [31:0] xc2_r [3];
  logic signed [63:0] mh2_r [3], mc2_r [3], mr2_r [3];

  logic signed [31:0] xh1 [3], xc1 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xh1[i] = llgs_pkg::sat32(llgs_pkg::ext40(llgs_pkg::rsat(ph1_r[i][0])) -
                               llgs_pkg::ext40(llgs_pkg::rsat(ph1_r[i][1])));
      xc1[i] = llgs_pkg::sat32(llgs_pkg::ext40(llgs_pkg::rsat(pc1_r[i][0])) -
                               llgs_pkg::ext40(llgs_pkg::rsat(pc1_r[i][1])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b2_r[i]  <= b1_r[i];
        h2_r[i]  <= h1_r[i];
        xc2_r[i] <= xc1[i];
        mh2_r[i] <= llgs_pkg::mul(dm_q, xh1[i]);
        mc2_r[i] <= llgs_pkg::mul(dm_q, tq_r[i]);
        mr2_r[i] <= llgs_pkg::mul(dm_q, xr1_r[i]);
      end
      r2_r <= r1_r;
    end
  end

  // ---------------- stage 3: step and noise gain products ----------------
  logic               v3_r;
  logic signed [31:0] b3_r [3];
  logic signed [63:0] q1_3_r [3], q2_3_r [3], q3_3_r [3];

  logic signed [31:0] t1_2 [3], t2_2 [3], t3_2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t1_2[i] = llgs_pkg::sat32(llgs_pkg::ext40(h2_r[i]) +
                                llgs_pkg::ext40(llgs_pkg::rsat(mh2_r[i])));
      t2_2[i] = llgs_pkg::sat32(llgs_pkg::ext40(llgs_pkg::rsat(mc2_r[i])) -
                                llgs_pkg::ext40(xc2_r[i]));
      t3_2[i] = llgs_pkg::sat32(
        llgs_pkg::ext40(r2_r[i] ? llgs_pkg::ONE_Q : -llgs_pkg::ONE_Q) +
        llgs_pkg::ext40(llgs_pkg::rsat(mr2_r[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b3_r[i]   <= b2_r[i];
        q1_3_r[i] <= llgs_pkg::mul(hs_q, t1_2[i]);
        q2_3_r[i] <= llgs_pkg::mul(hs_q, t2_2[i]);
        q3_3_r[i] <= llgs_pkg::mul(ng_q, t3_2[i]);
      end
    end
  end

  // ---------------- stage 4: A, b x A products, A outer products ----------
  logic               v4_r;
  logic signed [31:0] b4_r [3];
  logic signed [31:0] a4_r [3];
  logic signed [63:0] pba4_r [3][2];
  logic signed [63:0] sq4_r [3];
  logic signed [63:0] pp4_r [3];  // xy, xz, yz

  logic signed [31:0] a3 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a3[i] = llgs_pkg::sat32(-(llgs_pkg::ext40(llgs_pkg::rsat(q1_3_r[i])) +
                                llgs_pkg::ext40(llgs_pkg::rsat(q2_3_r[i])) +
                                llgs_pkg::ext40(llgs_pkg::rsat(q3_3_r[i]))));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b4_r[i]      <= b3_r[i];
        a4_r[i]      <= a3[i];
        pba4_r[i][0] <= llgs_pkg::mul(b3_r[(i + 1) % 3], a3[(i + 2) % 3]);
        pba4_r[i][1] <= llgs_pkg::mul(b3_r[(i + 2) % 3], a3[(i + 1) % 3]);
        sq4_r[i]     <= llgs_pkg::mul(a3[i], a3[i]);
      end
      pp4_r[0] <= llgs_pkg::mul(a3[0], a3[1]);
      pp4_r[1] <= llgs_pkg::mul(a3[0], a3[2]);
      pp4_r[2] <= llgs_pkg::mul(a3[1], a3[2]);
    end
  end

  // ---------------- stage 5: right side, matrix, denominator ----------------
  logic               v5_r;
  logic signed [31:0] b5_r [3];
  logic signed [31:0] rhs5_r [3];
  logic signed [31:0] cf5_r [3][3];
  logic [32:0]        d5_r;

  logic signed [31:0] rhs4 [3], s4 [3], xy4, xz4, yz4;
  logic signed [31:0] cf4 [3][3];
  logic signed [39:0] d4;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rhs4[i] = llgs_pkg::sat32(llgs_pkg::ext40(b4_r[i]) + llgs_pkg::ext40(
        llgs_pkg::sat32(llgs_pkg::ext40(llgs_pkg::rsat(pba4_r[i][0])) -
                        llgs_pkg::ext40(llgs_pkg::rsat(pba4_r[i][1])))));
      s4[i] = llgs_pkg::rsat(sq4_r[i]);
    end
    xy4 = llgs_pkg::rsat(pp4_r[0]);
    xz4 = llgs_pkg::rsat(pp4_r[1]);
    yz4 = llgs_pkg::rsat(pp4_r[2]);
    cf4[0][0] = llgs_pkg::sat32(llgs_pkg::ext40(llgs_pkg::ONE_Q) + llgs_pkg::ext40(s4[0]));
    cf4[0][1] = llgs_pkg::sat32(llgs_pkg::ext40(xy4) + llgs_pkg::ext40(a4_r[2]));
    cf4[0][2] = llgs_pkg::sat32(llgs_pkg::ext40(xz4) - llgs_pkg::ext40(a4_r[1]));
    cf4[1][0] = llgs_pkg::sat32(llgs_pkg::ext40(xy4) - llgs_pkg::ext40(a4_r[2]));
    cf4[1][1] = llgs_pkg::sat32(llgs_pkg::ext40(llgs_pkg::ONE_Q) + llgs_pkg::ext40(s4[1]));
    cf4[1][2] = llgs_pkg::sat32(llgs_pkg::ext40(yz4) + llgs_pkg::ext40(a4_r[0]));
    cf4[2][0] = llgs_pkg::sat32(llgs_pkg::ext40(xz4) + llgs_pkg::ext40(a4_r[1]));
    cf4[2][1] = llgs_pkg::sat32(llgs_pkg::ext40(yz4) - llgs_pkg::ext40(a4_r[0]));
    cf4[2][2] = llgs_pkg::sat32(llgs_pkg::ext40(llgs_pkg::ONE_Q) + llgs_pkg::ext40(s4[2]));
    d4 = llgs_pkg::ext40(llgs_pkg::ONE_Q) + llgs_pkg::ext40(s4[0]) +
         llgs_pkg::ext40(s4[1]) + llgs_pkg::ext40(s4[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b5_r[i]   <= b4_r[i];
        rhs5_r[i] <= rhs4[i];
        for (int j = 0; j < 3; j++) cf5_r[i][j] <= cf4[i][j];
      end
      d5_r <= d4[32:0];
    end
  end

  // ---------------- stage 6: row products ----------------
  logic               v6_r;
  logic signed [31:0] b6_r [3];
  logic signed [63:0] pr6_r [3][3];
  logic [32:0]        d6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b6_r[i] <= b5_r[i];
        for (int j = 0; j < 3; j++) pr6_r[i][j] <= llgs_pkg::mul(rhs5_r[j], cf5_r[i][j]);
      end
      d6_r <= d5_r;
    end
  end

  // ---------------- divider stages: one quotient bit each ----------------
  // stage 0 holds the row sums and the divider start value
  logic               dv_v_r   [NDS + 1];
  logic signed [31:0] dv_b_r   [NDS + 1][3];
  logic signed [33:0] dv_num_r [NDS + 1][3];
  logic [32:0]        dv_d_r   [NDS + 1];
  logic [33:0]        dv_rem_r [NDS + 1];
  logic [NDS-1:0]     dv_q_r   [NDS + 1];

  logic signed [31:0] rs6 [3][3];
  logic signed [33:0] num6 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) rs6[i][j] = llgs_pkg::rsat(pr6_r[i][j]);
      num6[i] = 34'(rs6[i][0]) + 34'(rs6[i][1]) + 34'(rs6[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= v6_r;
  end

  // dividend is 2^48 + d/2; its bits above the quotient range start the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_b_r[0][i]   <= b6_r[i];
        dv_num_r[0][i] <= num6[i];
      end
      dv_d_r[0]   <= d6_r;
      dv_rem_r[0] <= 34'd8388608 + {27'd0, d6_r[32:26]};
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar s = 0; s < NDS; s++) begin : g_div
    localparam int K = NDS - 1 - s;
    logic [34:0] cand;
    logic        take;
    always_comb begin
      cand = {dv_rem_r[s], dv_d_r[s][K + 1]};
      take = cand >= {2'b00, dv_d_r[s]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[s + 1] <= 1'b0;
      else if (en) dv_v_r[s + 1] <= dv_v_r[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_b_r[s + 1][i]   <= dv_b_r[s][i];
          dv_num_r[s + 1][i] <= dv_num_r[s][i];
        end
        dv_d_r[s + 1]   <= dv_d_r[s];
        dv_rem_r[s + 1] <= take ? 34'(cand - {2'b00, dv_d_r[s]}) : cand[33:0];
        dv_q_r[s + 1]   <= {dv_q_r[s][NDS-2:0], take};
      end
    end
  end

  // ---------------- apply reciprocal ----------------
  logic               vf_r;
  logic signed [31:0] bf_r [3];
  logic signed [63:0] sf_r [3];

  logic signed [63:0] rq;
  assign rq = {{(64 - NDS){1'b0}}, dv_q_r[NDS]};

  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else if (en) vf_r <= dv_v_r[NDS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        bf_r[i] <= dv_b_r[NDS][i];
        sf_r[i] <= {{30{dv_num_r[NDS][i][33]}}, dv_num_r[NDS][i]} * rq;
      end
    end
  end

  // ---------------- solved spin and midpoint, output register ----------------
  logic signed [31:0] sol [3], mid [3];
  logic signed [33:0] s2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sol[i] = llgs_pkg::rsat(sf_r[i]);
      s2[i]  = {{2{bf_r[i][31]}}, bf_r[i]} + {{2{sol[i][31]}}, sol[i]} + 34'sd1;
      mid[i] = 32'(s2[i] >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vf_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.solved_x <= sol[0];
      out_data.solved_y <= sol[1];
      out_data.solved_z <= sol[2];
      out_data.mid_x    <= mid[0];
      out_data.mid_y    <= mid[1];
      out_data.mid_z    <= mid[2];
    end
  end

endmodule

`default_nettype wire
